### rtl/core/mp1p_pkg.sv
// Shared types and constants for the 1-D padded max-pool core.
// No dependencies; imported by every module of the core.
package mp1p_pkg;

    localparam int DATA_W     = 32;
    localparam int IDX_W      = 16;
    localparam int POS_W      = 17;
    localparam int WINDOW_MAX = 16;
    localparam int PAD_MAX    = 15;
    localparam int WIN_W      = 5;
    localparam int STEP_W     = 5;
    localparam int PAD_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int RES_MAX    = 16;
    localparam int CNT_W      = $clog2(RES_MAX + 1);

    // -999999.0 in Q24.8
    localparam logic signed [DATA_W-1:0] PAD_VALUE = -32'sd255999744;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAD    = 2'd0,
        CFG_WINDOW = 2'd1,
        CFG_STEP   = 2'd2
    } cfg_reg_t;

    // Max token walking down the cell chain
    typedef struct packed {
        logic                     valid;
        logic [WIN_W-1:0]         rem;
        logic signed [DATA_W-1:0] best;
    } tok_t;

    typedef struct packed {
        logic                     shift;
        logic signed [DATA_W-1:0] value;
        tok_t                     tok;
    } chain_ctl_t;

endpackage

### rtl/core/max_pool_1d_padded_core.sv
// Streaming 1-D max pool with padding and stride: top level.
// Each item is stored as up to 31 chain elements with padding; for every
//   completed window the max token walks all 16 history cells while the
//   chain holds still.
// One item in flight; results leave through a one-deep output register.
// Reset: async active low; config returns to pad 0, window 2, step 2.
module max_pool_1d_padded_core
    import mp1p_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     last_sample,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [IDX_W-1:0]         window_index,
    output logic signed [DATA_W-1:0] window_max,
    output logic                     final_window
);

    chain_ctl_t               chain_ctl;
    logic signed [DATA_W-1:0] cell_val [WINDOW_MAX];
    tok_t                     cell_tok [WINDOW_MAX];

    mp1p_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_index (window_index),
        .window_max   (window_max),
        .final_window (final_window),
        .chain_ctl    (chain_ctl),
        .chain_tok    (cell_tok[WINDOW_MAX-1])
    );

    // cell 0 holds the newest element
    for (genvar k = 0; k < WINDOW_MAX; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            mp1p_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (chain_ctl.shift),
                .val_in  (chain_ctl.value),
                .tok_in  (chain_ctl.tok),
                .val_out (cell_val[k]),
                .tok_out (cell_tok[k])
            );
        end
        else
        begin : g_body
            mp1p_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (chain_ctl.shift),
                .val_in  (cell_val[k-1]),
                .tok_in  (cell_tok[k-1]),
                .val_out (cell_val[k]),
                .tok_out (cell_tok[k])
            );
        end
    end

endmodule

### rtl/core/mp1p_cell.sv
// One storage cell of the history chain: holds an element, shifts it on,
// and folds its element into a passing max token. Depends on mp1p_pkg.
module mp1p_cell
    import mp1p_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     shift,
    input  logic signed [DATA_W-1:0] val_in,
    input  tok_t                     tok_in,
    output logic signed [DATA_W-1:0] val_out,
    output tok_t                     tok_out
);

    logic signed [DATA_W-1:0] value_reg;
    logic                     tok_valid_reg;
    logic [WIN_W-1:0]         tok_rem_reg;
    logic signed [DATA_W-1:0] tok_best_reg;
    tok_t                     tok_next;

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && tok_in.rem != '0)
        begin
            if (value_reg > tok_in.best)
                tok_next.best = value_reg;
            tok_next.rem = tok_in.rem - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
            value_reg <= val_in;
        tok_rem_reg  <= tok_next.rem;
        tok_best_reg <= tok_next.best;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else
            tok_valid_reg <= tok_next.valid;
    end

    assign val_out = value_reg;
    assign tok_out = {tok_valid_reg, tok_rem_reg, tok_best_reg};

endmodule

### rtl/core/mp1p_ctrl.sv
// Sequencer for the padded max-pool core: config registers, padding,
// window bookkeeping, result staging and output register. Depends on mp1p_pkg.
module mp1p_ctrl
    import mp1p_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     last_sample,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [IDX_W-1:0]         window_index,
    output logic signed [DATA_W-1:0] window_max,
    output logic                     final_window,
    output chain_ctl_t               chain_ctl,
    input  tok_t                     chain_tok
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE,
        ST_SCAN,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_SAMPLE,
        PH_POST
    } phase_t;

    logic [PAD_W-1:0]  pad_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [STEP_W-1:0] step_reg;

    state_t                   state_reg;
    phase_t                   phase_reg;
    logic [PAD_W-1:0]         pads_left_reg;
    logic signed [DATA_W-1:0] sample_reg;
    logic                     last_reg;
    logic                     in_seq_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         nwe_reg;
    logic [IDX_W-1:0]         wins_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [IDX_W-1:0]         res_idx_reg;
    logic signed [DATA_W-1:0] res_max_reg;
    logic                     pend_valid_reg;
    logic [IDX_W-1:0]         pend_idx_reg;
    logic signed [DATA_W-1:0] pend_max_reg;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic signed [DATA_W-1:0] out_max_reg;
    logic                     out_final_reg;
    logic                     launch_valid_reg;
    logic [WIN_W-1:0]         launch_rem_reg;
    logic signed [DATA_W-1:0] launch_best_reg;

    logic [WIN_W-1:0]  win_eff;
    logic [STEP_W-1:0] step_eff;
    logic [PAD_W-1:0]  pad_eff;
    logic              hit;
    logic              out_free;
    logic              out_load;
    logic              adv_done;
    phase_t            adv_phase;
    logic [PAD_W-1:0]  adv_pads;
    state_t            adv_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg  <= '0;
            win_reg  <= WIN_W'(2);
            step_reg <= STEP_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PAD:    pad_reg  <= cfg_data[PAD_W-1:0];
                CFG_WINDOW: win_reg  <= cfg_data[WIN_W-1:0];
                CFG_STEP:   step_reg <= cfg_data[STEP_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (win_reg == '0)
            win_eff = WIN_W'(1);
        else if (win_reg > WIN_W'(WINDOW_MAX))
            win_eff = WIN_W'(WINDOW_MAX);
        else
            win_eff = win_reg;
        step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;
        pad_eff  = (pad_reg > PAD_W'(PAD_MAX)) ? PAD_W'(PAD_MAX) : pad_reg;
    end

    assign hit      = (pos_reg == nwe_reg);
    assign out_free = !out_valid_reg || out_ready;
    // staged result moves into the output register this cycle
    assign out_load = pend_valid_reg && out_free
                      && ((state_reg == ST_EMIT && cnt_reg < CNT_W'(RES_MAX))
                          || state_reg == ST_FLUSH);

    // what comes after the element just handled
    always_comb
    begin
        adv_done  = 1'b0;
        adv_phase = phase_reg;
        adv_pads  = pads_left_reg;
        unique case (phase_reg)
            PH_PRE:
            begin
                if (pads_left_reg > PAD_W'(1))
                    adv_pads = pads_left_reg - 1'b1;
                else
                    adv_phase = PH_SAMPLE;
            end
            PH_SAMPLE:
            begin
                if (last_reg && pad_eff != '0)
                begin
                    adv_phase = PH_POST;
                    adv_pads  = pad_eff;
                end
                else
                    adv_done = 1'b1;
            end
            PH_POST:
            begin
                if (pads_left_reg > PAD_W'(1))
                    adv_pads = pads_left_reg - 1'b1;
                else
                    adv_done = 1'b1;
            end
            default: adv_done = 1'b1;
        endcase
        adv_state = adv_done ? ST_FLUSH : ST_STORE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_SAMPLE;
            pads_left_reg    <= '0;
            last_reg         <= 1'b0;
            in_seq_reg       <= 1'b0;
            pos_reg          <= '0;
            nwe_reg          <= POS_W'(1);
            wins_reg         <= '0;
            cnt_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_final_reg    <= 1'b0;
            launch_valid_reg <= 1'b0;
        end
        else
        begin
            launch_valid_reg <= (state_reg == ST_STORE) && hit;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg  <= last_sample;
                        cnt_reg   <= '0;
                        phase_reg <= (!in_seq_reg && pad_eff != '0) ? PH_PRE : PH_SAMPLE;
                        if (!in_seq_reg)
                        begin
                            pos_reg  <= '0;
                            nwe_reg  <= POS_W'(win_eff - 1'b1);
                            wins_reg <= '0;
                            if (pad_eff != '0)
                                pads_left_reg <= pad_eff;
                        end
                        state_reg <= ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    pos_reg <= pos_reg + 1'b1;
                    if (hit)
                    begin
                        res_idx_reg <= wins_reg;
                        if (wins_reg != '1)
                            wins_reg <= wins_reg + 1'b1;
                        nwe_reg   <= nwe_reg + POS_W'(step_eff);
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        phase_reg     <= adv_phase;
                        pads_left_reg <= adv_pads;
                        state_reg     <= adv_state;
                    end
                end
                ST_SCAN:
                begin
                    if (chain_tok.valid)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    priority if (cnt_reg >= CNT_W'(RES_MAX))
                    begin
                        // window counted but dropped
                        phase_reg     <= adv_phase;
                        pads_left_reg <= adv_pads;
                        state_reg     <= adv_state;
                    end
                    else if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_idx_reg   <= pend_idx_reg;
                            out_max_reg   <= pend_max_reg;
                            out_final_reg <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_idx_reg   <= res_idx_reg;
                        pend_max_reg   <= res_max_reg;
                        cnt_reg        <= cnt_reg + 1'b1;
                        phase_reg      <= adv_phase;
                        pads_left_reg  <= adv_pads;
                        state_reg      <= adv_state;
                    end
                    else
                        state_reg <= ST_EMIT;
                end
                ST_FLUSH:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_idx_reg   <= pend_idx_reg;
                            out_max_reg   <= pend_max_reg;
                            out_final_reg <= last_reg;
                        end
                        pend_valid_reg <= 1'b0;
                        in_seq_reg     <= !last_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
            sample_reg <= sample;
        if (state_reg == ST_SCAN && chain_tok.valid)
            res_max_reg <= chain_tok.best;
        if (state_reg == ST_STORE)
        begin
            launch_rem_reg  <= win_eff;
            launch_best_reg <= PAD_VALUE;
        end
    end

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign window_index    = out_idx_reg;
    assign window_max      = out_max_reg;
    assign final_window    = out_final_reg;
    assign chain_ctl.shift = (state_reg == ST_STORE);
    assign chain_ctl.value = (phase_reg == PH_SAMPLE) ? sample_reg : PAD_VALUE;
    assign chain_ctl.tok   = {launch_valid_reg, launch_rem_reg, launch_best_reg};

`ifndef NO_ASSERTIONS
    // a staged result must be handed off before the next transfer is taken
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !pend_valid_reg)
        else $error("staged result left behind at idle");

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(RES_MAX))
        else $error("per-item result count overflow");

    // token only arrives while the chain is frozen for a scan
    a_tok_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain_tok.valid |-> state_reg == ST_SCAN)
        else $error("max token out of step with sequencer");

    a_accept_store: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == ST_STORE)
        else $error("accepted transfer not processed");
`endif

endmodule
